### design/irc_tok_pkg.sv
// irc_tok_pkg: shared types and constants of the irc message tokenizer
// result item layout, result kind codes, character codes, queue sizing
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package irc_tok_pkg;

  // default limits, handed to the top level parameters
  localparam int MAX_TOKENS_DEF  = 16;
  localparam int TOKEN_LIMIT_DEF = 512;

  // result queue depth, a power of two
  localparam int QDEPTH = 4;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  token_index;
    logic [7:0]  char_value;
    logic [8:0]  char_position;
    logic [3:0]  param_count;
    logic        last_result;
  } res_t;

  // zero, one or two results written to the queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    res_t       item0;
    res_t       item1;
  } push_t;

endpackage

`default_nettype wire

### design/irc_tok_if.sv
// irc_tok_in_if and irc_tok_out_if: valid/ready channels of the tokenizer
// depends on nothing but the field widths of the block
`timescale 1ns / 1ps
`default_nettype none

interface irc_tok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface irc_tok_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [3:0] token_index;
  logic [7:0] char_value;
  logic [8:0] char_position;
  logic [3:0] param_count;
  logic       last_result;

  modport source (output valid, output result_kind, output token_index,
                  output char_value, output char_position, output param_count,
                  output last_result, input ready);
  modport sink   (input valid, input result_kind, input token_index,
                  input char_value, input char_position, input param_count,
                  input last_result, output ready);
endinterface

`default_nettype wire

### design/irc_tok_core.sv
// irc_tok_core: input register, parse state and result generation
// depends on irc_tok_pkg
`timescale 1ns / 1ps
`default_nettype none

module irc_tok_core #(
  parameter int MAX_TOKENS  = irc_tok_pkg::MAX_TOKENS_DEF,
  parameter int TOKEN_LIMIT = irc_tok_pkg::TOKEN_LIMIT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         text_byte_i,
  input  wire logic               end_of_text_i,
  input  wire logic               room_i,
  output irc_tok_pkg::push_t      push_o
);

  localparam int TW = $clog2(MAX_TOKENS + 1);
  localparam int CW = $clog2(TOKEN_LIMIT + 1);

  localparam logic [1:0] MODE_NORMAL      = 2'd0;
  localparam logic [1:0] MODE_AFTER_SPACE = 2'd1;
  localparam logic [1:0] MODE_TRAILING    = 2'd2;
  localparam logic [1:0] MODE_IGNORE      = 2'd3;

  logic          valid_q, valid_d;
  logic [7:0]    byte_q;
  logic          eot_q;
  logic [1:0]    mode_q, mode_d;
  logic [TW-1:0] tok_q, tok_d;
  logic [CW-1:0] chars_q, chars_d;

  logic              fire;
  logic              close_en, keep_en;
  logic [TW-1:0]     tok_inc;
  irc_tok_pkg::res_t char_res, end_res, done_res;

  assign fire       = valid_q && room_i;
  assign in_ready_o = !valid_q || room_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;
  assign tok_inc    = tok_q + TW'(1);

  always_comb begin
    char_res               = '0;
    char_res.kind          = irc_tok_pkg::KIND_CHAR;
    char_res.token_index   = 4'(tok_q);
    char_res.char_value    = byte_q;
    char_res.char_position = 9'(chars_q);
    end_res                = '0;
    end_res.kind           = irc_tok_pkg::KIND_END;
    end_res.token_index    = 4'(tok_q);
    done_res               = '0;
    done_res.kind          = irc_tok_pkg::KIND_DONE;
    done_res.last_result   = 1'b1;
    done_res.param_count   = (mode_q == MODE_IGNORE) ? 4'(MAX_TOKENS - 1) : 4'(tok_q);
  end

  always_comb begin
    mode_d   = mode_q;
    tok_d    = tok_q;
    chars_d  = chars_q;
    push_o   = '0;
    close_en = 1'b0;
    keep_en  = 1'b0;
    if (fire) begin
      if (eot_q) begin
        if (mode_q == MODE_IGNORE) begin
          push_o.count = 2'd1;
          push_o.item0 = done_res;
        end else begin
          push_o.count = 2'd2;
          push_o.item0 = end_res;
          push_o.item1 = done_res;
        end
        mode_d  = MODE_NORMAL;
        tok_d   = '0;
        chars_d = '0;
      end else begin
        unique case (mode_q)
          MODE_NORMAL: begin
            if (byte_q == irc_tok_pkg::CHAR_SPACE) close_en = 1'b1;
            else keep_en = 1'b1;
          end
          MODE_AFTER_SPACE: begin
            if (byte_q == irc_tok_pkg::CHAR_COLON) begin
              mode_d = MODE_TRAILING;
            end else if (byte_q == irc_tok_pkg::CHAR_SPACE) begin
              close_en = 1'b1;
            end else begin
              mode_d  = MODE_NORMAL;
              keep_en = 1'b1;
            end
          end
          MODE_TRAILING: keep_en = 1'b1;
          default: ;
        endcase
        if (close_en) begin
          push_o.count = 2'd1;
          push_o.item0 = end_res;
          tok_d        = tok_inc;
          chars_d      = '0;
          mode_d       = (tok_inc >= TW'(MAX_TOKENS)) ? MODE_IGNORE : MODE_AFTER_SPACE;
        end
        // characters past the length limit are dropped
        if (keep_en && (chars_q < CW'(TOKEN_LIMIT))) begin
          push_o.count = 2'd1;
          push_o.item0 = char_res;
          chars_d      = chars_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mode_q  <= MODE_NORMAL;
      tok_q   <= '0;
      chars_q <= '0;
    end else begin
      valid_q <= valid_d;
      mode_q  <= mode_d;
      tok_q   <= tok_d;
      chars_q <= chars_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= text_byte_i;
      eot_q  <= end_of_text_i;
    end
  end

endmodule

`default_nettype wire

### design/irc_tok_resq.sv
// irc_tok_resq: small result queue, up to two writes and one read a cycle
// depends on irc_tok_pkg
`timescale 1ns / 1ps
`default_nettype none

module irc_tok_resq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire irc_tok_pkg::push_t  push_i,
  output logic                     room_o,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output irc_tok_pkg::res_t        head_o
);

  localparam int DEPTH = irc_tok_pkg::QDEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  irc_tok_pkg::res_t mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]     count_q, count_d;
  logic              pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign head_o  = mem_q[rd_ptr_q];
  // room for a pair, regardless of a read in the same cycle
  assign room_o  = (count_q <= NW'(DEPTH - 2));
  assign count_d = count_q + NW'(push_i.count) - NW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PW'(push_i.count);
      rd_ptr_q <= rd_ptr_q + PW'(pop);
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q] <= push_i.item0;
    if (push_i.count == 2'd2) mem_q[PW'(wr_ptr_q + PW'(1))] <= push_i.item1;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(DEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> (count_q <= NW'(DEPTH - 2)))
    else $error("results written without room");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + NW'($past(push_i.count)) - NW'($past(pop)))
    else $error("queue fill level out of step");

  a_no_push3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd3)
    else $error("illegal result count");

endmodule

`default_nettype wire

### design/irc_message_tokenizer_top.sv
// irc_message_tokenizer_top: irc message tokenizer, top level
// depends on irc_tok_pkg, irc_tok_if, irc_tok_core, irc_tok_resq
//
// usage
//   in_i carries one message byte per request, end_of_text closes the
//   message (text_byte is then ignored). out_o carries result
//   requests: token characters with index and position, a token end
//   marker per token, and at end of text a done result with the
//   parameter count and last_result set.
//   throughput: one input request per cycle; an end-of-text request
//   yields up to two results and the output side delivers one per cycle,
//   so the input side is held when the result queue has no room for a
//   pair. results pass the input register, then the result queue, on
//   their way to out_o.
//   a stalled receiver fills the four-entry result queue; once fewer than
//   two slots are free, in_i.ready drops until results are taken.
//   reset clears the parse state, the input register and the queue; the
//   block is ready for a new message in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module irc_message_tokenizer_top #(
  parameter int MAX_TOKENS  = irc_tok_pkg::MAX_TOKENS_DEF,
  parameter int TOKEN_LIMIT = irc_tok_pkg::TOKEN_LIMIT_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  irc_tok_in_if.sink    in_i,
  irc_tok_out_if.source out_o
);

  irc_tok_pkg::push_t push;
  irc_tok_pkg::res_t  head;
  logic               room;
  logic               in_ready;
  logic               out_valid;

  // parse state machine behind the input register
  irc_tok_core #(
    .MAX_TOKENS  (MAX_TOKENS),
    .TOKEN_LIMIT (TOKEN_LIMIT)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_ready),
    .text_byte_i   (in_i.text_byte),
    .end_of_text_i (in_i.end_of_text),
    .room_i        (room),
    .push_o        (push)
  );

  // results wait here so the parser keeps going while out_o stalls
  irc_tok_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_valid),
    .ready_i (out_o.ready),
    .head_o  (head)
  );

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid;
  assign out_o.result_kind   = head.kind;
  assign out_o.token_index   = head.token_index;
  assign out_o.char_value    = head.char_value;
  assign out_o.char_position = head.char_position;
  assign out_o.param_count   = head.param_count;
  assign out_o.last_result   = head.last_result;

endmodule

`default_nettype wire

### bench/irc_message_tokenizer_top_test.sv
// irc_message_tokenizer_top_test: self-checking bench for the irc message tokenizer
// feeds message bytes on in_i, predicts every result and checks it on out_o
// depends on irc_tok_pkg, irc_tok_if and the design top irc_message_tokenizer_top
`timescale 1ns / 1ps

module irc_message_tokenizer_top_test;

  localparam int MAX_TOK        = irc_tok_pkg::MAX_TOKENS_DEF;
  localparam int TOK_LIMIT      = irc_tok_pkg::TOKEN_LIMIT_DEF;
  // cycles with no request on either side before the run is called hung
  localparam int WATCHDOG_LIMIT = 2000;
  // bytes the block actually acts on in the random phase
  localparam int RANDOM_ITEMS   = 400;
  // long receiver hold-off used to fill the result queue
  localparam int HOLD_CYCLES    = 200;
  // settle time at the end
  localparam int SETTLE_CYCLES  = 20;

  // parser states of the predictor
  typedef enum logic [1:0] {
    ST_IN_TOKEN    = 2'd0,
    ST_AFTER_SPACE = 2'd1,
    ST_TRAILING    = 2'd2,
    ST_DISCARD     = 2'd3
  } scan_state_e;

  logic clk_i;
  logic rst_ni;

  irc_tok_in_if  in_if ();
  irc_tok_out_if out_if ();

  irc_message_tokenizer_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // tokenizer predictor state
  scan_state_e       scan_st = ST_IN_TOKEN;
  int                tok_num = 0;   // index of the token being built
  int                tok_len = 0;   // characters kept in that token
  irc_tok_pkg::res_t token_results[$];

  // run bookkeeping
  int errors          = 0;
  int useful_items    = 0;
  int results_checked = 0;
  int msgs_closed     = 0;
  int limit_msgs      = 0;
  int overlong_drops  = 0;
  int idle_cycles     = 0;

  // pacing controls shared by sender and receiver
  bit quiet     = 1'b0;  // no random gaps on either side
  int hold_left = 0;     // receiver hold-off, counted down by the receiver

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // gap lengths: mostly none, often a few cycles, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic void emit(irc_tok_pkg::kind_e k, logic [3:0] idx, logic [7:0] ch,
                               logic [8:0] pos, logic [3:0] cnt, logic last);
    irc_tok_pkg::res_t r;
    r.kind          = k;
    r.token_index   = idx;
    r.char_value    = ch;
    r.char_position = pos;
    r.param_count   = cnt;
    r.last_result   = last;
    token_results.push_back(r);
  endfunction

  // characters past the length limit vanish without a result
  function automatic void keep_char(logic [7:0] ch);
    if (tok_len >= TOK_LIMIT) begin
      overlong_drops++;
    end else begin
      emit(irc_tok_pkg::KIND_CHAR, 4'(tok_num), ch, 9'(tok_len), 4'd0, 1'b0);
      tok_len++;
    end
  endfunction

  // a separating space ends the token; the last allowed token mutes the rest
  function automatic void close_token();
    emit(irc_tok_pkg::KIND_END, 4'(tok_num), 8'd0, 9'd0, 4'd0, 1'b0);
    tok_num++;
    tok_len = 0;
    scan_st = (tok_num >= MAX_TOK) ? ST_DISCARD : ST_AFTER_SPACE;
  endfunction

  function automatic void tokenize_step(logic [7:0] b, logic eot);
    if (eot) begin
      if (scan_st == ST_DISCARD) begin
        // token limit hit: only the done result, count pinned one below the limit
        emit(irc_tok_pkg::KIND_DONE, 4'd0, 8'd0, 9'd0, 4'(MAX_TOK - 1), 1'b1);
        limit_msgs++;
      end else begin
        emit(irc_tok_pkg::KIND_END, 4'(tok_num), 8'd0, 9'd0, 4'd0, 1'b0);
        emit(irc_tok_pkg::KIND_DONE, 4'd0, 8'd0, 9'd0, 4'(tok_num), 1'b1);
      end
      msgs_closed++;
      scan_st = ST_IN_TOKEN;
      tok_num = 0;
      tok_len = 0;
    end else begin
      case (scan_st)
        ST_IN_TOKEN: begin
          if (b == irc_tok_pkg::CHAR_SPACE) close_token();
          else keep_char(b);
        end
        ST_AFTER_SPACE: begin
          if (b == irc_tok_pkg::CHAR_COLON) begin
            scan_st = ST_TRAILING;
          end else if (b == irc_tok_pkg::CHAR_SPACE) begin
            close_token();
          end else begin
            scan_st = ST_IN_TOKEN;
            keep_char(b);
          end
        end
        ST_TRAILING: keep_char(b);
        default: ;
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------
  // monitor: predicts on every input request, checks every result request,
  // and watches for a hang
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    irc_tok_pkg::res_t want;
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        // bytes dropped after the token limit do not count as work
        if (in_if.end_of_text || scan_st != ST_DISCARD) useful_items++;
        tokenize_step(in_if.text_byte, in_if.end_of_text);
      end
      if (out_if.valid && out_if.ready) begin
        results_checked++;
        if (token_results.size() == 0) begin
          $error("unexpected result: kind %0d token %0d char %0h pos %0d count %0d",
                 out_if.result_kind, out_if.token_index, out_if.char_value,
                 out_if.char_position, out_if.param_count);
          errors++;
        end else begin
          want = token_results.pop_front();
          if (out_if.result_kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, out_if.result_kind);
            errors++;
          end
          if (out_if.token_index !== want.token_index) begin
            $error("token_index: expected %0d, got %0d",
                   want.token_index, out_if.token_index);
            errors++;
          end
          if (out_if.char_value !== want.char_value) begin
            $error("char_value: expected %0h, got %0h", want.char_value, out_if.char_value);
            errors++;
          end
          if (out_if.char_position !== want.char_position) begin
            $error("char_position: expected %0d, got %0d",
                   want.char_position, out_if.char_position);
            errors++;
          end
          if (out_if.param_count !== want.param_count) begin
            $error("param_count: expected %0d, got %0d",
                   want.param_count, out_if.param_count);
            errors++;
          end
          if (out_if.last_result !== want.last_result) begin
            $error("last_result: expected %0d, got %0d",
                   want.last_result, out_if.last_result);
            errors++;
          end
        end
      end
      // watchdog on request activity
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: random stalls, plus the long hold-off that the queue test asks
  // ---------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (!quiet) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------
  // sender helpers
  // ---------------------------------------------------------------------

  // offer one byte, wait for the request to be taken, then maybe idle;
  // valid stays high into the next call when there is no gap
  task automatic send_text(input logic [7:0] b, input logic eot);
    int gap;
    in_if.valid       <= 1'b1;
    in_if.text_byte   <= b;
    in_if.end_of_text <= eot;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // closing request; the byte rides along but is ignored
  task automatic send_eot();
    send_text(8'($urandom), 1'b1);
  endtask

  task automatic send_msg(input string s);
    for (int i = 0; i < s.len(); i++) send_text(s[i], 1'b0);
    send_eot();
  endtask

  // sender pause until every predicted result has been taken
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (token_results.size() != 0) @(posedge clk_i);
  endtask

  // character inside a normal token: never a space, bit 7 reachable
  function automatic logic [7:0] rand_word_char();
    int          r;
    logic [7:0]  c;
    r = $urandom_range(0, 9);
    if (r < 2) c = 8'($urandom_range(0, 255));
    else if (r == 2) c = irc_tok_pkg::CHAR_COLON;
    else c = 8'($urandom_range(8'h41, 8'h7a));
    if (c == irc_tok_pkg::CHAR_SPACE) c = 8'h5f;
    return c;
  endfunction

  // character of a trailing token: spaces and colons are frequent
  function automatic logic [7:0] rand_trail_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return irc_tok_pkg::CHAR_SPACE;
    if (r == 3) return irc_tok_pkg::CHAR_COLON;
    return 8'($urandom_range(0, 255));
  endfunction

  // one random message: mostly well formed, sometimes noise or unclosed
  task automatic send_random_message();
    int ntok;
    int len;
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) begin
      // sometimes enough tokens to run into the token limit
      ntok = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
      for (int t = 0; t < ntok; t++) begin
        if (t > 0) send_text(irc_tok_pkg::CHAR_SPACE, 1'b0);
        len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 5);
        for (int i = 0; i < len; i++) send_text(rand_word_char(), 1'b0);
      end
      r = $urandom_range(0, 9);
      if (r < 3) begin
        send_text(irc_tok_pkg::CHAR_SPACE, 1'b0);
        send_text(irc_tok_pkg::CHAR_COLON, 1'b0);
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) send_text(rand_trail_char(), 1'b0);
      end else if (r == 3) begin
        send_text(irc_tok_pkg::CHAR_SPACE, 1'b0);
      end
      send_eot();
    end else begin
      // noise, heavy on spaces and colons; left open now and then
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 2);
        send_text(r == 0 ? irc_tok_pkg::CHAR_SPACE :
                  r == 1 ? irc_tok_pkg::CHAR_COLON : 8'($urandom), 1'b0);
      end
      if ($urandom_range(0, 3) != 0) send_eot();
    end
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // short hand-picked messages covering the basic grammar
  task automatic test_basic_messages();
    send_eot();                 // empty message: one empty token, count zero
    send_msg("A  B ");          // double space and a space at the end give empty tokens
    send_msg(":x y");           // colon at message start is plain text
    send_msg("Q :a :b");        // trailing token keeps spaces and later colons
    send_text(8'h00, 1'b0);     // extreme byte values as characters
    send_text(8'hff, 1'b0);
    send_eot();
    wait_drained();
  endtask

  // messages that reach the token limit
  task automatic test_token_limit();
    // the last space closes the final allowed token; the trailing part is muted
    send_text("a", 1'b0);
    for (int i = 0; i < MAX_TOK; i++) send_text(irc_tok_pkg::CHAR_SPACE, 1'b0);
    send_msg(":tail x");
    // one token short of the limit: the trailing token still counts
    for (int i = 0; i < MAX_TOK - 1; i++) send_text(irc_tok_pkg::CHAR_SPACE, 1'b0);
    send_msg(":end");
    // limit reached and text closed right away
    for (int i = 0; i < MAX_TOK; i++) send_text(irc_tok_pkg::CHAR_SPACE, 1'b0);
    send_eot();
    wait_drained();
  endtask

  // tokens longer than the length limit, normal and trailing
  task automatic test_overlong_tokens();
    for (int i = 0; i < TOK_LIMIT + 3; i++) send_text(rand_word_char(), 1'b0);
    send_msg(" b");
    send_msg("x :");
    for (int i = 0; i < TOK_LIMIT + 8; i++) send_text(rand_trail_char(), 1'b0);
    send_eot();
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering: the result queue
  // fills and the input side must stall without losing anything
  task automatic test_full_queue_stall();
    quiet = 1'b1;
    hold_left = HOLD_CYCLES;
    send_msg("PRIVMSG #chan :hello there");
    for (int i = 0; i < 6; i++) send_eot();  // back-to-back pairs of results
    send_msg("A B C D E F");
    quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_messages();
    int start;
    start = useful_items;
    while (useful_items - start < RANDOM_ITEMS) begin
      // some messages run with no gaps at all
      quiet = ($urandom_range(0, 7) == 0);
      send_random_message();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    quiet = 1'b0;
    // close whatever noise left open
    send_eot();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.text_byte   = 8'd0;
    in_if.end_of_text = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_messages();
    test_token_limit();
    test_overlong_tokens();
    test_full_queue_stall();
    test_random_messages();

    // everything taken; let the block settle to catch stray results
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run: %0d bytes acted on, %0d results checked, %0d messages closed",
             useful_items, results_checked, msgs_closed);
    $display("     %0d hit the token limit, %0d characters dropped past the length limit",
             limit_msgs, overlong_drops);
    if (errors == 0 && token_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, token_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
design/irc_tok_pkg.sv
design/irc_tok_if.sv
design/irc_tok_core.sv
design/irc_tok_resq.sv
design/irc_message_tokenizer_top.sv
bench/irc_message_tokenizer_top_test.sv
